[rtl/fps_pkg.sv]
// fps_pkg: shared types, constants and codes for the fitness proportional selector
// used by every module of the block and by its port checker
// no dependencies
package fps_pkg;

   // sizing
   localparam int MAX_POPULATION = 256;
   localparam int FITNESS_BITS   = 16;
   localparam int IDX_W          = $clog2(MAX_POPULATION);
   localparam int CNT_W          = IDX_W + 1;
   localparam int TOTAL_W        = 24;
   localparam int RND_W          = 31;
   localparam int CHOSEN_W       = 8;
   localparam int PROD_W         = TOTAL_W + RND_W;
   localparam int DVD_W          = PROD_W + 1;
   localparam int STEPS_W        = $clog2(DVD_W + 1);

   // item kinds
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_LOAD   = 2'd1;
   localparam logic [1:0] KIND_SELECT = 2'd2;

   // selection modes (the unused code behaves as uniform)
   localparam logic [1:0] MODE_UNIFORM  = 2'd0;
   localparam logic [1:0] MODE_ROULETTE = 2'd1;
   localparam logic [1:0] MODE_SUS      = 2'd2;

   // request and response words
   typedef struct packed {
      logic [1:0]              kind;
      logic [FITNESS_BITS-1:0] fitness_value;
      logic [RND_W-1:0]        random_value;
   } req_word_type;

   typedef struct packed {
      logic [CHOSEN_W-1:0] chosen_index;
      logic                select_error;
   } rsp_word_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STRIDE_GO,
      ST_STRIDE_WAIT,
      ST_MUL,
      ST_MOD_GO,
      ST_MOD_WAIT,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_OUT
   } state_type;

   // divider control and status
   typedef struct packed {
      logic               start;
      logic [DVD_W-1:0]   dividend;
      logic [TOTAL_W-1:0] divisor;
      logic [STEPS_W-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic               done;
      logic [TOTAL_W-1:0] quotient;
      logic [TOTAL_W-1:0] remainder;
   } div_sts_type;

endpackage

[rtl/fps_table.sv]
// fps_table: cumulative fitness table, one write port and one registered read port
// depends on fps_pkg
module fps_table (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [fps_pkg::IDX_W-1:0]   wr_addr,
   input  logic [fps_pkg::TOTAL_W-1:0] wr_data,
   input  logic [fps_pkg::IDX_W-1:0]   rd_addr,
   output logic [fps_pkg::TOTAL_W-1:0] rd_data
);
   import fps_pkg::*;

   logic [TOTAL_W-1:0] mem [MAX_POPULATION];
   logic [TOTAL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fps_div.sv]
// fps_div: shared restoring divider, one quotient bit per cycle
// dividend arrives left aligned; runs for the given number of steps
// depends on fps_pkg
module fps_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fps_pkg::div_ctl_type ctl,
   output fps_pkg::div_sts_type sts
);
   import fps_pkg::*;

   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [TOTAL_W-1:0] den_ff, den_in;
   logic [STEPS_W-1:0] cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [TOTAL_W:0]   trial;
   logic [TOTAL_W:0]   diff;
   logic               fits;

   // one restoring step
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   // next values
   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in = '0;
         dvd_in = ctl.dividend;
         den_in = ctl.divisor;
         cnt_in = ctl.steps;
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
         dvd_in  = {dvd_ff[DVD_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == STEPS_W'(1));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
   end

   assign sts.done      = done_ff;
   assign sts.quotient  = dvd_ff[TOTAL_W-1:0];
   assign sts.remainder = rem_ff;

endmodule

[rtl/fitness_proportional_selector.sv]
// fitness_proportional_selector: roulette wheel selector for a genetic algorithm
// start and load words leave the input free; a select word goes straight out on error, else
// through a modulo on the shared divider (uniform), plus a binary search if needed (roulette),
// or a stride divide, multiply, modulo and search (stochastic universal); one quotient bit per
// cycle, read and compare states per probe; input free as the result shows, later if stalled
// synchronous active high reset clears count, total, step and sets roulette mode, not the table
module fitness_proportional_selector (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fps_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fps_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_wr_data
);
   import fps_pkg::*;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_POPULATION);
   localparam logic [RND_W-1:0] STEP_MAX  = '1;
   localparam logic [TOTAL_W:0] TOTAL_MAX = {1'b0, {TOTAL_W{1'b1}}};

   state_type state_ff, state_in;

   logic [1:0]              mode_ff, mode_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [FITNESS_BITS-1:0] first_ff, first_in;
   logic [RND_W-1:0]        step_ff, step_in;
   logic [RND_W-1:0]        opnd_ff, opnd_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [TOTAL_W-1:0]      v_ff, v_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        mid_ff, mid_in;
   logic [CHOSEN_W-1:0]     idx_ff, idx_in;
   logic                    err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;

   logic               req_fire;
   logic               sel_fire;
   logic               no_data;
   logic               is_sus;
   logic               is_roulette;
   logic               out_free;
   logic [RND_W-1:0]   step_use;
   logic [TOTAL_W:0]   load_sum;
   logic [TOTAL_W-1:0] load_sat;
   logic [CNT_W:0]     mid_sum;
   logic               tbl_wr_en;
   logic [TOTAL_W-1:0] tbl_rd_data;
   div_ctl_type        div_ctl;
   div_sts_type        div_sts;

   // shared divider
   fps_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   // cumulative table, read address taken from the next probe so data lines up with mid_ff
   fps_table u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (load_sat),
      .rd_addr (mid_in[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   // handshake and decode
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      req_fire    = req_valid && !req_stall;
      sel_fire    = req_fire && (req_word.kind == KIND_SELECT);
      no_data     = (count_ff == '0) || (total_ff == '0);
      is_sus      = (mode_ff == MODE_SUS);
      is_roulette = (mode_ff == MODE_ROULETTE);
      out_free    = !rsp_valid_ff || !rsp_stall;
      step_use    = (step_ff == STEP_MAX) ? '0 : step_ff;
      load_sum    = {1'b0, total_ff} + (TOTAL_W+1)'(req_word.fitness_value);
      load_sat    = (load_sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : load_sum[TOTAL_W-1:0];
      mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
      tbl_wr_en   = req_fire && (req_word.kind == KIND_LOAD) && (count_ff < MAX_COUNT);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sel_fire) begin
               if (no_data) begin
                  state_in = ST_OUT;
               end else if (is_sus) begin
                  state_in = ST_STRIDE_GO;
               end else begin
                  state_in = ST_MOD_GO;
               end
            end
         end
         ST_STRIDE_GO:   state_in = ST_STRIDE_WAIT;
         ST_STRIDE_WAIT: if (div_sts.done) state_in = ST_MUL;
         ST_MUL:         state_in = ST_MOD_GO;
         ST_MOD_GO:      state_in = ST_MOD_WAIT;
         ST_MOD_WAIT: begin
            if (div_sts.done) begin
               if (is_roulette) begin
                  state_in = (div_sts.remainder <= TOTAL_W'(first_ff)) ? ST_OUT : ST_SRCH_RD;
               end else if (is_sus) begin
                  state_in = (div_sts.remainder == '0) ? ST_OUT : ST_SRCH_RD;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SRCH_RD:  state_in = (lo_ff < hi_ff) ? ST_SRCH_CMP : ST_OUT;
         ST_SRCH_CMP: state_in = ST_SRCH_RD;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // divider operands
   always_comb begin
      div_ctl.start    = 1'b0;
      div_ctl.dividend = {opnd_ff, {(DVD_W-RND_W){1'b0}}};
      div_ctl.divisor  = TOTAL_W'(count_ff);
      div_ctl.steps    = STEPS_W'(RND_W);
      unique case (state_ff)
         ST_STRIDE_GO: begin
            div_ctl.start    = 1'b1;
            div_ctl.dividend = {total_ff, {(DVD_W-TOTAL_W){1'b0}}};
            div_ctl.steps    = STEPS_W'(TOTAL_W);
         end
         ST_MOD_GO: begin
            div_ctl.start = 1'b1;
            if (is_sus) begin
               div_ctl.dividend = {prod_ff, {(DVD_W-PROD_W){1'b0}}};
               div_ctl.divisor  = total_ff;
               div_ctl.steps    = STEPS_W'(PROD_W);
            end else if (is_roulette) begin
               div_ctl.divisor = total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // table and step bookkeeping
   always_comb begin
      mode_in  = csr_wr_en ? csr_wr_data : mode_ff;
      count_in = count_ff;
      total_in = total_ff;
      first_in = first_ff;
      step_in  = step_ff;
      opnd_in  = opnd_ff;
      if (req_fire && (req_word.kind == KIND_START)) begin
         count_in = '0;
         total_in = '0;
         first_in = '0;
      end
      if (tbl_wr_en) begin
         count_in = count_ff + 1'b1;
         total_in = load_sat;
         if (count_ff == '0) begin
            first_in = req_word.fitness_value;
         end
      end
      if (sel_fire) begin
         if (is_sus && !no_data) begin
            opnd_in = step_use;
            step_in = step_use + 1'b1;
         end else begin
            opnd_in = req_word.random_value;
         end
      end
   end

   // selection datapath
   always_comb begin
      prod_in = prod_ff;
      v_in    = v_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      mid_in  = mid_ff;
      idx_in  = idx_ff;
      err_in  = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sel_fire) begin
               idx_in = '0;
               err_in = no_data;
            end
         end
         ST_MUL: prod_in = PROD_W'(div_sts.quotient * opnd_ff);
         ST_MOD_WAIT: begin
            if (div_sts.done) begin
               v_in   = div_sts.remainder;
               lo_in  = '0;
               hi_in  = count_ff;
               idx_in = (is_roulette || is_sus) ? '0 : CHOSEN_W'(div_sts.remainder);
            end
         end
         ST_SRCH_RD: begin
            mid_in = mid_sum[CNT_W:1];
            if (!(lo_ff < hi_ff)) begin
               idx_in = (lo_ff >= count_ff) ? CHOSEN_W'(count_ff - 1'b1) : CHOSEN_W'(lo_ff);
            end
         end
         ST_SRCH_CMP: begin
            if (tbl_rd_data > v_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.chosen_index = idx_ff;
         rsp_word_in.select_error = err_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_ROULETTE;
         count_ff     <= '0;
         total_ff     <= '0;
         first_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         first_ff     <= first_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      opnd_ff     <= opnd_in;
      prod_ff     <= prod_in;
      v_ff        <= v_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      idx_ff      <= idx_in;
      err_ff      <= err_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/fps_checker.sv]
// fps_checker: port level checks for fitness_proportional_selector, bound to the top level
// depends on fps_pkg and fitness_proportional_selector
module fps_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input fps_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input fps_pkg::rsp_word_type rsp_word
);
   import fps_pkg::*;

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   // an error word always carries index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_word.select_error || (rsp_word.chosen_index == '0))
      else $error("error word with nonzero index");

   // a select word keeps the input side busy in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_word.kind == KIND_SELECT) |=> req_stall)
      else $error("select word did not occupy the block");

   // start, load and other non-select words leave the input free in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_word.kind != KIND_SELECT) |=> !req_stall)
      else $error("non-select word stalled the input");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fitness_proportional_selector fps_checker u_fps_checker (.*);

[bench/fitness_proportional_selector_tb.sv]
// fitness_proportional_selector_tb: self-checking bench for the roulette wheel selector
// directed table then random generations, checked against an in-bench selection model
// depends on fps_pkg and fitness_proportional_selector
module fitness_proportional_selector_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fps_pkg::*;

   // codes the package leaves out
   localparam logic [1:0] KIND_NOP   = 2'd3;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [RND_W-1:0]   STEP_ALL_ONES = {RND_W{1'b1}};
   localparam logic [TOTAL_W:0]   SUM_CEIL      = {1'b0, {TOTAL_W{1'b1}}};
   localparam int                 SETTLE_CYCLES = 150;
   localparam int                 CYCLE_LIMIT   = 600_000;
   localparam int                 PHASE_WORDS   = 205;

   // one directed word, with its expected pick pinned where it is obvious
   typedef struct packed {
      logic [1:0]              mode;
      logic [1:0]              kind;
      logic [FITNESS_BITS-1:0] fit;
      logic [RND_W-1:0]        rnd;
      logic                    pinned;
      logic [CHOSEN_W-1:0]     idx;
      logic                    err;
   } probe_row_type;

   localparam int NPROBE = 25;
   localparam probe_row_type PROBES [NPROBE] = '{
      // empty table straight after reset
      '{MODE_ROULETTE, KIND_SELECT, 16'h0000, 31'h7FFF_FFFF, 1'b1, 8'd0, 1'b1},
      // zero total
      '{MODE_ROULETTE, KIND_LOAD,   16'h0000, 31'h0000_0000, 1'b0, 8'd0, 1'b0},
      '{MODE_ROULETTE, KIND_SELECT, 16'h0000, 31'h0000_3039, 1'b1, 8'd0, 1'b1},
      // fresh generation, unused fields all ones
      '{MODE_ROULETTE, KIND_START,  16'hFFFF, 31'h7FFF_FFFF, 1'b0, 8'd0, 1'b0},
      '{MODE_ROULETTE, KIND_LOAD,   16'hFFFF, 31'h7FFF_FFFF, 1'b0, 8'd0, 1'b0},
      '{MODE_ROULETTE, KIND_LOAD,   16'h0000, 31'h0000_0000, 1'b0, 8'd0, 1'b0},
      '{MODE_ROULETTE, KIND_LOAD,   16'h0001, 31'h0000_0000, 1'b0, 8'd0, 1'b0},
      '{MODE_ROULETTE, KIND_LOAD,   16'h8000, 31'h0000_0000, 1'b0, 8'd0, 1'b0},
      // value zero and value equal to the first fitness both land on entry 0
      '{MODE_ROULETTE, KIND_SELECT, 16'hFFFF, 31'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{MODE_ROULETTE, KIND_SELECT, 16'h0000, 31'h7FFF_FFFF, 1'b0, 8'd0, 1'b0},
      '{MODE_ROULETTE, KIND_SELECT, 16'h0000, 31'h0000_FFFF, 1'b1, 8'd0, 1'b0},
      '{MODE_ROULETTE, KIND_SELECT, 16'h0000, 31'h0001_0000, 1'b0, 8'd0, 1'b0},
      // unused kind gives nothing back
      '{MODE_ROULETTE, KIND_NOP,    16'hFFFF, 31'h7FFF_FFFF, 1'b0, 8'd0, 1'b0},
      '{MODE_UNIFORM,  KIND_SELECT, 16'h0000, 31'h7FFF_FFFF, 1'b0, 8'd0, 1'b0},
      '{MODE_UNIFORM,  KIND_SELECT, 16'hFFFF, 31'h0000_0000, 1'b1, 8'd0, 1'b0},
      // first sampling step is zero, so entry 0
      '{MODE_SUS,      KIND_SELECT, 16'h0000, 31'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{MODE_SUS,      KIND_SELECT, 16'hFFFF, 31'h7FFF_FFFF, 1'b0, 8'd0, 1'b0},
      '{MODE_SUS,      KIND_SELECT, 16'h0000, 31'h0000_0000, 1'b0, 8'd0, 1'b0},
      '{MODE_SUS,      KIND_SELECT, 16'h0000, 31'h0000_0000, 1'b0, 8'd0, 1'b0},
      // spare mode acts as uniform
      '{MODE_SPARE,    KIND_SELECT, 16'h0000, 31'h7FFF_FFFF, 1'b0, 8'd0, 1'b0},
      '{MODE_SPARE,    KIND_START,  16'h0000, 31'h0000_0000, 1'b0, 8'd0, 1'b0},
      '{MODE_SPARE,    KIND_SELECT, 16'h0000, 31'h0000_0000, 1'b1, 8'd0, 1'b1},
      // empty table in sampling mode holds the step
      '{MODE_SUS,      KIND_SELECT, 16'h0000, 31'h0000_0000, 1'b1, 8'd0, 1'b1},
      '{MODE_SUS,      KIND_LOAD,   16'h0005, 31'h0000_0000, 1'b0, 8'd0, 1'b0},
      '{MODE_SUS,      KIND_SELECT, 16'h0000, 31'h0000_0000, 1'b0, 8'd0, 1'b0}
   };

   // dut ports
   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_word_type req_word    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_wr_en   = 1'b0;
   logic [1:0]   csr_wr_data = '0;

   // pinned expectation travels with the request word
   logic         req_pin_en  = 1'b0;
   rsp_word_type req_pin     = '0;

   // selection model state
   logic [TOTAL_W-1:0]      cum_fitness [MAX_POPULATION];
   logic [CNT_W-1:0]        entry_cnt;
   logic [TOTAL_W-1:0]      fit_total;
   logic [FITNESS_BITS-1:0] fit_first;
   logic [RND_W-1:0]        sample_step;
   logic [1:0]              mode_now;

   rsp_word_type due_picks [$];
   rsp_word_type model_pick;
   rsp_word_type want;
   bit           model_hit;
   bit           mismatch_seen = 1'b0;
   bit           steady        = 1'b0;
   logic [1:0]   mode_set      = MODE_ROULETTE;
   int           words_sent    = 0;
   int           cycle_count   = 0;

   fitness_proportional_selector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // first loaded entry whose running sum is above v
   function automatic int unsigned first_above(input longint unsigned v);
      int unsigned i;
      for (i = 0; i < entry_cnt; i++) begin
         if (cum_fitness[i] > v) return i;
      end
      return entry_cnt - 1;
   endfunction

   // apply one accepted word to the model, hit set when a pick comes back
   function automatic void select_member(input req_word_type w, output bit hit,
                                         output rsp_word_type pick);
      logic [TOTAL_W:0] sum;
      longint unsigned  v;
      longint unsigned  stride;
      int unsigned      idx;
      hit  = 1'b0;
      pick = '0;
      idx  = 0;
      case (w.kind)
         KIND_START: begin
            entry_cnt = '0;
            fit_total = '0;
            fit_first = '0;
         end
         KIND_LOAD: begin
            // table full: load dropped
            if (entry_cnt < MAX_POPULATION) begin
               sum = fit_total + w.fitness_value;
               if (sum > SUM_CEIL) sum = SUM_CEIL;
               if (entry_cnt == 0) fit_first = w.fitness_value;
               cum_fitness[entry_cnt] = sum[TOTAL_W-1:0];
               fit_total = sum[TOTAL_W-1:0];
               entry_cnt++;
            end
         end
         KIND_SELECT: begin
            hit = 1'b1;
            if (entry_cnt == 0 || fit_total == 0) begin
               pick.select_error = 1'b1;
            end else if (mode_now == MODE_ROULETTE) begin
               v   = w.random_value % fit_total;
               idx = (v <= fit_first) ? 0 : first_above(v);
            end else if (mode_now == MODE_SUS) begin
               if (sample_step == STEP_ALL_ONES) sample_step = '0;
               stride = fit_total / entry_cnt;
               v      = (stride * sample_step) % fit_total;
               idx    = (v == 0) ? 0 : first_above(v);
               sample_step++;
            end else begin
               idx = w.random_value % entry_cnt;
            end
            pick.chosen_index = idx[CHOSEN_W-1:0];
         end
         default: ;
      endcase
   endfunction

   // model update on accepted words, compare on accepted results
   always @(posedge clock) begin
      if (reset) begin
         entry_cnt   = '0;
         fit_total   = '0;
         fit_first   = '0;
         sample_step = '0;
         mode_now    = MODE_ROULETTE;
      end else begin
         if (csr_wr_en) mode_now = csr_wr_data;
         if (req_valid && !req_stall) begin
            select_member(req_word, model_hit, model_pick);
            if (model_hit) begin
               due_picks.insert(due_picks.size(), req_pin_en ? req_pin : model_pick);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_picks.size() == 0) begin
               $error("rsp word with no pick pending: index %0d error %0d",
                      rsp_word.chosen_index, rsp_word.select_error);
               mismatch_seen = 1'b1;
            end else begin
               want = due_picks.pop_front();
               if (rsp_word.chosen_index !== want.chosen_index) begin
                  $error("chosen_index: expected %0d, got %0d",
                         want.chosen_index, rsp_word.chosen_index);
                  mismatch_seen = 1'b1;
               end
               if (rsp_word.select_error !== want.select_error) begin
                  $error("select_error: expected %0d, got %0d",
                         want.select_error, rsp_word.select_error);
                  mismatch_seen = 1'b1;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99, 0) < 27);
   end

   function automatic logic [RND_W-1:0] draw_random();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(7, 0) == 0) r = $urandom_range(300, 0);
      return r[RND_W-1:0];
   endfunction

   // drive one word, hold it until accepted
   task automatic send_word(input logic [1:0] kind, input logic [FITNESS_BITS-1:0] fit,
                            input logic [RND_W-1:0] rnd, input bit pinned,
                            input rsp_word_type pin);
      req_word_type w;
      w.kind          = kind;
      w.fitness_value = fit;
      w.random_value  = rnd;
      @(negedge clock);
      while (!steady && $urandom_range(99, 0) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_word   <= w;
      req_pin_en <= pinned;
      req_pin    <= pin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind != KIND_NOP) words_sent++;
   endtask

   // wait for the block to go quiet, then write the mode
   task automatic set_mode(input logic [1:0] m);
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_picks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mode_set = m;
   endtask

   // start, loads with the odd stray word mixed in, then picks
   task automatic run_generation(input int loads, input int picks, input bit barren);
      logic [31:0]             noise;
      logic [FITNESS_BITS-1:0] fit;
      int unsigned             r;
      noise = $urandom;
      send_word(KIND_START, noise[FITNESS_BITS-1:0], draw_random(), 1'b0, '0);
      for (int i = 0; i < loads; i++) begin
         r     = $urandom_range(99, 0);
         noise = $urandom;
         if (r < 4) begin
            send_word(KIND_NOP, noise[FITNESS_BITS-1:0], draw_random(), 1'b0, '0);
         end else if (r < 9) begin
            send_word(KIND_SELECT, noise[FITNESS_BITS-1:0], draw_random(), 1'b0, '0);
         end
         case ($urandom_range(9, 0))
            0:       fit = '0;
            1:       fit = '1;
            2, 3:    fit = $urandom_range(15, 0);
            default: fit = noise[31:16];
         endcase
         if (barren) fit = '0;
         send_word(KIND_LOAD, fit, draw_random(), 1'b0, '0);
      end
      for (int i = 0; i < picks; i++) begin
         noise = $urandom;
         send_word(KIND_SELECT, noise[FITNESS_BITS-1:0], draw_random(), 1'b0, '0);
      end
   endtask

   // main sequence
   initial begin
      logic [1:0]   phase_modes [4];
      rsp_word_type pin;
      int           phase_base;
      int unsigned  r;
      int           loads;
      phase_modes = '{MODE_UNIFORM, MODE_SUS, MODE_ROULETTE, MODE_SPARE};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words
      for (int i = 0; i < NPROBE; i++) begin
         if (PROBES[i].mode != mode_set) set_mode(PROBES[i].mode);
         pin.chosen_index = PROBES[i].idx;
         pin.select_error = PROBES[i].err;
         send_word(PROBES[i].kind, PROBES[i].fit, PROBES[i].rnd, PROBES[i].pinned, pin);
      end

      // random generations, one phase per mode; second phase runs without idling
      for (int p = 0; p < 4; p++) begin
         set_mode(phase_modes[p]);
         steady     = (p == 1);
         phase_base = words_sent;
         // one overfull table
         if (p == 0) run_generation(MAX_POPULATION + 2, 12, 1'b0);
         while (words_sent - phase_base < PHASE_WORDS) begin
            r = $urandom_range(99, 0);
            if (r < 7)       loads = 0;
            else if (r < 17) loads = $urandom_range(40, 13);
            else             loads = $urandom_range(12, 1);
            run_generation(loads, $urandom_range(10, 1), $urandom_range(11, 0) == 0);
         end
         steady = 1'b0;
      end

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!mismatch_seen) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/fps_pkg.sv
rtl/fps_table.sv
rtl/fps_div.sv
rtl/fitness_proportional_selector.sv
rtl/fps_checker.sv
bench/fitness_proportional_selector_tb.sv
